/* hw/rtl/ttta_pkg.sv */
// ----------------------------------------------------------------------------
// ttta_pkg: shared types and constants for the timer tick time accumulator
// Holds word layouts, the duration clamp limits and the reciprocal constants
// used for the tick/microsecond conversions.
// ----------------------------------------------------------------------------
package ttta_pkg;

    // width of the wrapping microsecond clock
    localparam int TIME_BITS = 64;

    // stream word layouts
    localparam int IN_DATA_W  = 56;  // duration_us, counter_sample, wrap_seen, pad
    localparam int IN_USER_W  = 1;   // req_type
    localparam int OUT_DATA_W = 80;  // load_count, time_us
    localparam int OUT_USER_W = 1;   // result_kind

    // field widths
    localparam int DUR_W   = 32;
    localparam int CNT_W   = 16;
    localparam int TICKS_W = CNT_W + 1;
    localparam int TIME_W  = 64;

    // request and result kinds
    typedef enum logic [0:0] {
        REQ_SCHEDULE = 1'b0,
        REQ_SAMPLE   = 1'b1
    } req_kind_t;

    // duration clamp in microseconds
    localparam logic [DUR_W-1:0] MIN_US = 32'd250;
    localparam logic [DUR_W-1:0] MAX_US = 32'd54932;

    // load = floor(d * 1193 / 1000) as (d * ceil(2^32 * 1.193)) >> 32
    localparam int               LOAD_RECIP_W = 33;
    localparam logic [LOAD_RECIP_W-1:0] LOAD_RECIP = 33'd5123895985;
    localparam int               LOAD_PROD_W  = CNT_W + LOAD_RECIP_W;

    // us = floor(ticks * 1000 / 1193) as (ticks * ceil(2^32 * 1000 / 1193)) >> 32
    localparam int               US_RECIP_W = 32;
    localparam logic [US_RECIP_W-1:0] US_RECIP = 32'd3600140232;
    localparam int               US_PROD_W  = TICKS_W + US_RECIP_W;

    // common fraction width of both reciprocals
    localparam int RECIP_SHIFT = 32;

endpackage

/* hw/rtl/timer_tick_time_accumulator.sv */
// ----------------------------------------------------------------------------
// timer_tick_time_accumulator: time keeping for a 16-bit one-shot timer
// A schedule word clamps the duration and returns the tick count to load; a
// sample word turns the ticks passed since the last reference into us and
// adds them to a wrapping clock, returning the new time.
// ----------------------------------------------------------------------------
// Pipeline: a word passes the input register, tick stage, multiply stage
// and result register in that order before its result is presented.
// Throughput: one word per cycle; each stage is elastic, so a held result
// only stops the stages behind it once they fill.
// Reset: rst_n clears all valids, the clock, the reference count and the
// handled-wrap mark.
module timer_tick_time_accumulator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] duration_us, [47:32] counter_sample, [48] wrap_seen, [55:49] zero
    input  logic [ttta_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] req_type
    input  logic [ttta_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] load_count, [79:16] time_us
    output logic [ttta_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] result_kind
    output logic [ttta_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import ttta_pkg::*;

    // input register
    logic              in_valid_reg;
    req_kind_t         in_kind_reg;
    logic [DUR_W-1:0]  in_dur_reg;
    logic [CNT_W-1:0]  in_sample_reg;
    logic              in_wrap_reg;

    // tick stage
    logic                a_valid_reg;
    req_kind_t           a_kind_reg;
    logic [CNT_W-1:0]    a_load_reg;
    logic [TICKS_W-1:0]  a_ticks_reg;

    // multiply stage
    logic                  b_valid_reg;
    req_kind_t             b_kind_reg;
    logic [CNT_W-1:0]      b_load_reg;
    logic [US_PROD_W-1:0]  b_prod_reg;

    // result register
    logic               out_valid_reg;
    req_kind_t          out_kind_reg;
    logic [CNT_W-1:0]   out_load_reg;
    logic [TIME_W-1:0]  out_time_reg;

    // timer state
    logic [TIME_BITS-1:0] clock_reg;
    logic [TIME_BITS-1:0] clock_next;
    logic [CNT_W-1:0]     ref_reg;
    logic [CNT_W-1:0]     ref_next;
    logic                 wrap_handled_reg;
    logic                 wrap_handled_next;

    // stage advance enables
    logic out_load;
    logic b_load;
    logic a_load;
    logic in_load;

    // combinational stage values
    logic [DUR_W-1:0]       dur_clamped;
    logic [LOAD_PROD_W-1:0] load_prod;
    logic [CNT_W-1:0]       load_count;
    logic [TICKS_W-1:0]     ticks;
    logic [CNT_W-1:0]       sample_neg;

    // elastic handshake chain, output side first
    assign out_load      = b_valid_reg && (!out_valid_reg || m_axis_tready);
    assign b_load        = a_valid_reg && (!b_valid_reg || out_load);
    assign a_load        = in_valid_reg && (!a_valid_reg || b_load);
    assign s_axis_tready = !in_valid_reg || a_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // schedule: clamp and convert to ticks
    always_comb
    begin
        dur_clamped = in_dur_reg;
        if (in_dur_reg < MIN_US)
        begin
            dur_clamped = MIN_US;
        end
        else if (in_dur_reg > MAX_US)
        begin
            dur_clamped = MAX_US;
        end
        load_prod  = LOAD_PROD_W'(dur_clamped[CNT_W-1:0]) * LOAD_PROD_W'(LOAD_RECIP);
        load_count = load_prod[RECIP_SHIFT +: CNT_W];
    end

    // sample: ticks passed since the reference
    assign sample_neg = CNT_W'(0) - in_sample_reg;

    always_comb
    begin
        if (in_wrap_reg && !wrap_handled_reg)
        begin
            ticks = {1'b0, ref_reg} + {1'b0, sample_neg};
        end
        else if (ref_reg != '0)
        begin
            ticks = {1'b0, CNT_W'(ref_reg - in_sample_reg)};
        end
        else
        begin
            ticks = {1'b1, {CNT_W{1'b0}}} - {1'b0, in_sample_reg};
        end
    end

    // reference and wrap mark follow each word as it leaves the input register
    always_comb
    begin
        ref_next          = ref_reg;
        wrap_handled_next = wrap_handled_reg;
        if (a_load)
        begin
            if (in_kind_reg == REQ_SCHEDULE)
            begin
                ref_next          = load_count;
                wrap_handled_next = 1'b0;
            end
            else
            begin
                ref_next = in_sample_reg;
                if (in_wrap_reg)
                begin
                    wrap_handled_next = 1'b1;
                end
            end
        end
    end

    // clock accumulates in result order
    always_comb
    begin
        clock_next = clock_reg;
        if (out_load && (b_kind_reg == REQ_SAMPLE))
        begin
            clock_next = clock_reg
                       + TIME_BITS'(b_prod_reg[US_PROD_W-1:RECIP_SHIFT]);
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            clock_reg        <= '0;
            ref_reg          <= '0;
            wrap_handled_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (!a_valid_reg || b_load)
            begin
                a_valid_reg <= a_load;
            end
            if (!b_valid_reg || out_load)
            begin
                b_valid_reg <= b_load;
            end
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg <= out_load;
            end
            clock_reg        <= clock_next;
            ref_reg          <= ref_next;
            wrap_handled_reg <= wrap_handled_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_kind_reg   <= req_kind_t'(s_axis_tuser[0]);
            in_dur_reg    <= s_axis_tdata[DUR_W-1:0];
            in_sample_reg <= s_axis_tdata[DUR_W +: CNT_W];
            in_wrap_reg   <= s_axis_tdata[DUR_W + CNT_W];
        end
        if (a_load)
        begin
            a_kind_reg  <= in_kind_reg;
            a_load_reg  <= load_count;
            a_ticks_reg <= ticks;
        end
        if (b_load)
        begin
            b_kind_reg <= a_kind_reg;
            b_load_reg <= a_load_reg;
            b_prod_reg <= US_PROD_W'(a_ticks_reg) * US_PROD_W'(US_RECIP);
        end
        if (out_load)
        begin
            out_kind_reg <= b_kind_reg;
            if (b_kind_reg == REQ_SCHEDULE)
            begin
                out_load_reg <= b_load_reg;
                out_time_reg <= '0;
            end
            else
            begin
                out_load_reg <= '0;
                out_time_reg <= TIME_W'(clock_next);
            end
        end
    end

    // output word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_time_reg, out_load_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

/* dv/timer_tick_time_accumulator_tb.sv */
// ----------------------------------------------------------------------------
// timer_tick_time_accumulator_tb: self-checking bench for the tick time keeper
// Streams schedule and counter sample words into the block, predicts each
// result in the bench and compares every field of every result word in order.
// Covers clamp limits, wrap handling and long random load/sample sequences.
// Both stream sides stall at random.
// ----------------------------------------------------------------------------
module timer_tick_time_accumulator_tb;

    import ttta_pkg::*;

    localparam int unsigned TICKS_PER_MS = 1193;
    localparam int unsigned US_PER_MS    = 1000;
    localparam int unsigned STALL_PCT    = 29;
    localparam int unsigned TOTAL_WORDS  = 1100;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned IDLE_LIMIT   = 2000;

    // one expected result word
    typedef struct packed {
        req_kind_t   kind;
        logic [15:0] load;
        logic [63:0] time_us;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [31:0] duration_us, [47:32] counter_sample, [48] wrap_seen, [55:49] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] req_type
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] load_count, [79:16] time_us
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] result_kind
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // bench copy of the time keeping state
    logic [63:0] acc_clock_us;
    logic [15:0] acc_ref_count;
    logic        acc_wrap_handled;

    tick_result_t pending_results[$];

    bit          no_idle = 1'b0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned failures = 0;
    int unsigned idle_cycles = 0;
    int unsigned sched_count = 0;
    int unsigned clamp_count = 0;
    int unsigned sample_count = 0;
    int unsigned first_wrap_count = 0;

    timer_tick_time_accumulator DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // expected result of one word, advances the bench state
    function automatic tick_result_t predict_timer_word(req_kind_t kind, logic [31:0] dur,
                                                        logic [15:0] cnt, logic wrap);
        tick_result_t res;
        logic [63:0]  d;
        logic [63:0]  ticks;
        res = '0;
        res.kind = kind;
        if (kind == REQ_SCHEDULE)
        begin
            d = {32'd0, dur};
            if (d < MIN_US || d > MAX_US)
                clamp_count++;
            if (d < MIN_US)
                d = MIN_US;
            if (d > MAX_US)
                d = MAX_US;
            acc_ref_count = 16'((d * TICKS_PER_MS) / US_PER_MS);
            acc_wrap_handled = 1'b0;
            res.load = acc_ref_count;
            sched_count++;
        end
        else
        begin
            if (wrap && !acc_wrap_handled)
            begin
                // first wrap since the load: rest of the load plus the new lap
                ticks = {48'd0, acc_ref_count};
                if (cnt != 16'd0)
                    ticks += 64'd65536 - cnt;
                acc_wrap_handled = 1'b1;
                first_wrap_count++;
            end
            else if (acc_ref_count != 16'd0)
                ticks = {48'd0, 16'(acc_ref_count - cnt)};
            else
                ticks = 64'd65536 - cnt;
            acc_clock_us = acc_clock_us + (ticks * US_PER_MS) / TICKS_PER_MS;
            acc_ref_count = cnt;
            res.time_us = acc_clock_us;
            sample_count++;
        end
        return res;
    endfunction

    // send one word, stalling at random first
    task automatic push_timer_word(req_kind_t kind, logic [31:0] dur, logic [15:0] cnt,
                                   logic wrap);
        while (!no_idle && $urandom_range(99) < STALL_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, wrap, cnt, dur};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_timer_word(kind, dur, cnt, wrap));
        words_sent++;
    endtask

    task automatic push_schedule(logic [31:0] dur);
        push_timer_word(REQ_SCHEDULE, dur, 16'($urandom), 1'($urandom));
    endtask

    task automatic push_sample(logic [15:0] cnt, logic wrap);
        push_timer_word(REQ_SAMPLE, $urandom, cnt, wrap);
    endtask

    // hold the sender until every result is back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // one load followed by a few samples counting down, maybe a wrap
    task automatic run_load_cycle();
        int unsigned n;
        int unsigned step;
        logic [15:0] cur;
        if ($urandom_range(9) == 0)
            push_schedule($urandom);
        else
            push_schedule($urandom_range(MAX_US + 200, MIN_US - 150));
        cur = acc_ref_count;
        n = $urandom_range(5);
        repeat (n)
        begin
            step = $urandom_range((cur < 16'd3000) ? cur : 3000);
            cur = cur - 16'(step);
            push_sample(cur, 1'b0);
        end
        if ($urandom_range(99) < 60)
        begin
            // counter ran out and reloaded at the top
            cur = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
            push_sample(cur, 1'b1);
            n = $urandom_range(3);
            repeat (n)
            begin
                step = $urandom_range((cur < 16'd8000) ? cur : 8000);
                cur = cur - 16'(step);
                push_sample(cur, 1'($urandom));
            end
        end
    endtask

    // one word with every field at random
    task automatic push_noise_word();
        push_timer_word(req_kind_t'($urandom_range(1)), $urandom, 16'($urandom),
                        1'($urandom));
    endtask

    // durations around and beyond the clamp limits
    task automatic test_schedule_limits();
        push_schedule(32'd0);
        push_schedule(32'd1);
        push_schedule(32'd249);
        push_schedule(32'd250);
        push_schedule(32'd251);
        push_schedule(32'd1000);
        push_schedule(32'd54931);
        push_schedule(32'd54932);
        push_schedule(32'd54933);
        push_schedule(32'hFFFF_FFFF);
        push_schedule(32'h5555_5555);
    endtask

    // each branch of the tick computation
    task automatic test_sample_cases();
        // count down to zero, then a sample from the zero reference, no wrap
        push_timer_word(REQ_SCHEDULE, 32'd0, 16'hFFFF, 1'b1);
        push_sample(16'd100, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        // ordinary countdown and a sample above the reference
        push_schedule(32'd1000);
        push_sample(16'd1000, 1'b0);
        push_sample(16'd1100, 1'b0);
        // first wrap with sample zero, then a handled wrap
        push_schedule(32'd20000);
        push_timer_word(REQ_SAMPLE, 32'hAAAA_AAAA, 16'd0, 1'b1);
        push_sample(16'd65000, 1'b1);
        // first wrap with a nonzero sample, full-scale load
        push_schedule(32'd54932);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h8000, 1'b1);
    endtask

    // back-to-back words with no stalls on either side
    task automatic test_steady_stream();
        int unsigned stop;
        stop = words_sent + 150;
        no_idle = 1'b1;
        while (words_sent < stop)
            run_load_cycle();
        no_idle = 1'b0;
    endtask

    // sender waits for the block to empty between bursts
    task automatic test_drain_pauses();
        repeat (6)
        begin
            run_load_cycle();
            wait_results_drained();
        end
    endtask

    // mostly well-formed load cycles with some random noise
    task automatic test_random_traffic();
        while (words_sent < TOTAL_WORDS)
        begin
            if ($urandom_range(99) < 75)
                run_load_cycle();
            else
                push_noise_word();
        end
    endtask

    // result checking, output stalls and idle cycle count
    always @(posedge clk)
    begin
        tick_result_t exp_res;
        logic [15:0]  act_load;
        logic [63:0]  act_time;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                act_load = m_axis_tdata[15:0];
                act_time = m_axis_tdata[79:16];
                if (pending_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result word kind %0d load %0d time %0d",
                             $time, m_axis_tuser[0], act_load, act_time);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (m_axis_tuser[0] !== exp_res.kind)
                    begin
                        failures++;
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, exp_res.kind, m_axis_tuser[0]);
                    end
                    if (act_load !== exp_res.load)
                    begin
                        failures++;
                        $display("%0t: load_count expected %0d actual %0d",
                                 $time, exp_res.load, act_load);
                    end
                    if (act_time !== exp_res.time_us)
                    begin
                        failures++;
                        $display("%0t: time_us expected %0d actual %0d",
                                 $time, exp_res.time_us, act_time);
                    end
                end
            end
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= STALL_PCT);
        end
    end

    // watchdog on cycles with no accepted word
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // test sequence
    initial
    begin
        acc_clock_us = '0;
        acc_ref_count = '0;
        acc_wrap_handled = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_schedule_limits();
        test_sample_cases();
        test_steady_stream();
        test_drain_pauses();
        test_random_traffic();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            failures++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("covered %0d words: %0d loads (%0d clamped), %0d samples (%0d first wraps)",
                 words_sent, sched_count, clamp_count, sample_count, first_wrap_count);
        $display("checked %0d result words, %0d field errors", results_seen, failures);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
